>>> rtl/keyed_alloc_ledger_top_k_macros.svh
// Assertion macros shared by the ledger RTL.
`ifndef KEYED_ALLOC_LEDGER_TOP_K_MACROS_SVH
`define KEYED_ALLOC_LEDGER_TOP_K_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define KAL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property whose consequent must hold in the cycle after its antecedent.
`define KAL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/kal_pkg.sv
package kal_pkg;

  localparam int TABLE_ENTRIES = 128;
  localparam int TOP_COUNT     = 8;
  localparam int MAX_RESULTS   = 8;
  localparam int RANK_LIMIT    = (TOP_COUNT > MAX_RESULTS) ? MAX_RESULTS : TOP_COUNT;

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int RANK_W = 3;

  localparam logic [CNT_W-1:0]  TABLE_CNT = CNT_W'(TABLE_ENTRIES);
  localparam logic [RANK_W-1:0] LAST_RANK = RANK_W'(RANK_LIMIT - 1);

  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] calls;
    logic [31:0] bytes;
  } kal_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REC_SCAN,
    ST_REC_UPD,
    ST_REP_SCAN,
    ST_REP_EMIT
  } kal_state_e;

endpackage

>>> rtl/kal_if.sv
interface kal_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] caller_key;
  logic [31:0] alloc_bytes;

  modport source (output valid, output kind, output caller_key, output alloc_bytes,
                  input ready);
  modport sink   (input valid, input kind, input caller_key, input alloc_bytes,
                  output ready);
endinterface

interface kal_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  rank;
  logic        found;
  logic [31:0] key_out;
  logic [31:0] bytes_out;
  logic [31:0] calls_out;
  logic [31:0] total_out;
  logic [31:0] overflow_out;
  logic        last;

  modport source (output valid, output rank, output found, output key_out,
                  output bytes_out, output calls_out, output total_out,
                  output overflow_out, output last, input ready);
  modport sink   (input valid, input rank, input found, input key_out,
                  input bytes_out, input calls_out, input total_out,
                  input overflow_out, input last, output ready);
endinterface

>>> rtl/keyed_alloc_ledger_top_k.sv
// A record reads the used entries one per cycle until its key matches, then writes the
// entry back with updated counts, or adds a new one; when the table is full it counts a drop.
// A report rescans the used entries through the same read port for each ranked key and
// emits one result per key, at most 8; an output stall holds the report until it is taken.
// Reset is asynchronous, active low: it clears the sequencer, the entry count,
// the total and the overflow count; table contents are undefined until written.
`include "keyed_alloc_ledger_top_k_macros.svh"

module keyed_alloc_ledger_top_k
  import kal_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  kal_in_if.sink    in_i,
  kal_out_if.source out_o
);

  kal_state_e state_q, state_d;

  kal_entry_t entry_mem_q [TABLE_ENTRIES];
  kal_entry_t rdata_q;

  logic [CNT_W-1:0]  used_q, used_d;
  logic [31:0]       dropped_q, dropped_d;
  logic [31:0]       total_q, total_d;

  logic [CNT_W-1:0]  idx_q, idx_d;
  logic              pend_q, pend_d;
  logic [IDX_W-1:0]  pidx_q, pidx_d;
  logic [31:0]       key_q, key_d;
  logic [31:0]       add_q, add_d;
  logic              hit_q, hit_d;
  logic [IDX_W-1:0]  widx_q, widx_d;

  logic [RANK_W-1:0] rank_q, rank_d;
  logic              first_q, first_d;
  logic [31:0]       prevb_q, prevb_d;
  logic [IDX_W-1:0]  previdx_q, previdx_d;
  kal_entry_t        best_q, best_d;
  logic [IDX_W-1:0]  bestidx_q, bestidx_d;
  logic              bestfound_q, bestfound_d;

  logic              ov_q, ov_d;
  logic [RANK_W-1:0] orank_q, orank_d;
  logic              ofound_q, ofound_d;
  logic              olast_q, olast_d;
  kal_entry_t        oent_q, oent_d;
  logic [31:0]       ototal_q, ototal_d;
  logic [31:0]       oover_q, oover_d;

  logic              in_acc;
  logic              more_w;
  logic              hit_w;
  logic              elig_w;
  logic              emit_w;
  logic              drop_w;
  logic              rd_en;
  logic              we;
  kal_entry_t        wdata;

  assign in_acc = in_i.valid && in_i.ready;
  assign more_w = idx_q < used_q;
  assign hit_w  = pend_q && (rdata_q.key == key_q);
  assign emit_w = !ov_q || out_o.ready;
  assign drop_w = (state_q == ST_REC_UPD) && !hit_q && (used_q == TABLE_CNT);
  assign elig_w = pend_q && (rdata_q.bytes != 32'd0) && (rdata_q.bytes > best_q.bytes) &&
                  (first_q || (rdata_q.bytes < prevb_q) ||
                   ((rdata_q.bytes == prevb_q) && (pidx_q > previdx_q)));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = (in_i.kind == KIND_REPORT) ? ST_REP_SCAN : ST_REC_SCAN;
        end
      end
      ST_REC_SCAN: begin
        if (hit_w || !more_w) begin
          state_d = ST_REC_UPD;
        end
      end
      ST_REC_UPD: state_d = ST_IDLE;
      ST_REP_SCAN: begin
        if (!more_w && !pend_q) begin
          state_d = ST_REP_EMIT;
        end
      end
      ST_REP_EMIT: begin
        if (emit_w) begin
          state_d = (bestfound_q && (rank_q != LAST_RANK)) ? ST_REP_SCAN : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready = 1'b0;
    rd_en      = 1'b0;
    we         = 1'b0;
    wdata      = '{key: key_q, calls: 32'd1, bytes: add_q};
    case (state_q)
      ST_IDLE:     in_i.ready = 1'b1;
      ST_REC_SCAN: rd_en = !hit_w && more_w;
      ST_REC_UPD: begin
        if (hit_q) begin
          we    = 1'b1;
          wdata = '{key: key_q, calls: rdata_q.calls + 32'd1, bytes: rdata_q.bytes + add_q};
        end else if (used_q < TABLE_CNT) begin
          we = 1'b1;
        end
      end
      ST_REP_SCAN: rd_en = more_w;
      ST_REP_EMIT: ;
      default: ;
    endcase
  end

  always_comb begin
    used_d      = used_q;
    dropped_d   = dropped_q;
    total_d     = total_q;
    idx_d       = idx_q;
    pend_d      = rd_en;
    pidx_d      = rd_en ? idx_q[IDX_W-1:0] : pidx_q;
    key_d       = key_q;
    add_d       = add_q;
    hit_d       = hit_q;
    widx_d      = widx_q;
    rank_d      = rank_q;
    first_d     = first_q;
    prevb_d     = prevb_q;
    previdx_d   = previdx_q;
    best_d      = best_q;
    bestidx_d   = bestidx_q;
    bestfound_d = bestfound_q;
    ov_d        = ov_q && !out_o.ready;
    orank_d     = orank_q;
    ofound_d    = ofound_q;
    olast_d     = olast_q;
    oent_d      = oent_q;
    ototal_d    = ototal_q;
    oover_d     = oover_q;
    if (rd_en) begin
      idx_d = idx_q + CNT_W'(1);
    end
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          key_d       = in_i.caller_key;
          add_d       = in_i.alloc_bytes;
          idx_d       = '0;
          rank_d      = '0;
          first_d     = 1'b1;
          best_d      = '0;
          bestfound_d = 1'b0;
        end
      end
      ST_REC_SCAN: begin
        if (hit_w) begin
          hit_d  = 1'b1;
          widx_d = pidx_q;
        end else if (!more_w) begin
          hit_d  = 1'b0;
          widx_d = used_q[IDX_W-1:0];
        end
      end
      ST_REC_UPD: begin
        if (hit_q || (used_q < TABLE_CNT)) begin
          total_d = total_q + add_q;
          if (!hit_q) begin
            used_d = used_q + CNT_W'(1);
          end
        end else begin
          dropped_d = dropped_q + 32'd1;
        end
      end
      ST_REP_SCAN: begin
        if (elig_w) begin
          best_d      = rdata_q;
          bestidx_d   = pidx_q;
          bestfound_d = 1'b1;
        end
      end
      ST_REP_EMIT: begin
        if (emit_w) begin
          ov_d     = 1'b1;
          orank_d  = rank_q;
          ofound_d = bestfound_q;
          olast_d  = !bestfound_q || (rank_q == LAST_RANK);
          oent_d   = bestfound_q ? best_q : '0;
          ototal_d = total_q;
          oover_d  = dropped_q;
          rank_d      = rank_q + RANK_W'(1);
          first_d     = 1'b0;
          prevb_d     = best_q.bytes;
          previdx_d   = bestidx_q;
          best_d      = '0;
          bestfound_d = 1'b0;
          idx_d       = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      entry_mem_q[widx_q] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= entry_mem_q[idx_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      used_q    <= '0;
      dropped_q <= '0;
      total_q   <= '0;
      pend_q    <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      dropped_q <= dropped_d;
      total_q   <= total_d;
      pend_q    <= pend_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    pidx_q      <= pidx_d;
    key_q       <= key_d;
    add_q       <= add_d;
    hit_q       <= hit_d;
    widx_q      <= widx_d;
    rank_q      <= rank_d;
    first_q     <= first_d;
    prevb_q     <= prevb_d;
    previdx_q   <= previdx_d;
    best_q      <= best_d;
    bestidx_q   <= bestidx_d;
    bestfound_q <= bestfound_d;
    orank_q     <= orank_d;
    ofound_q    <= ofound_d;
    olast_q     <= olast_d;
    oent_q      <= oent_d;
    ototal_q    <= ototal_d;
    oover_q     <= oover_d;
  end

  assign out_o.valid        = ov_q;
  assign out_o.rank         = orank_q;
  assign out_o.found        = ofound_q;
  assign out_o.key_out      = oent_q.key;
  assign out_o.bytes_out    = oent_q.bytes;
  assign out_o.calls_out    = oent_q.calls;
  assign out_o.total_out    = ototal_q;
  assign out_o.overflow_out = oover_q;
  assign out_o.last         = olast_q;

  `KAL_ASSERT_ALWAYS(a_used_bound, used_q <= TABLE_CNT, "entry count exceeds table size")
  `KAL_ASSERT_ALWAYS(a_marker_last, !(ov_q && !ofound_q) || olast_q, "end marker without last")
  `KAL_ASSERT_NEXT(a_total_stable, state_q != ST_REC_UPD, $stable(total_q), "total changed")
  `KAL_ASSERT_NEXT(a_drop_count, drop_w, dropped_q == $past(dropped_q) + 32'd1, "drop not counted")

endmodule
